/* hdl/amso_pkg.sv */
// Package for the amplitude-modulated sine oscillator: widths, register codes and sine table.
package amso_pkg;

    localparam int PhaseBits     = 32;
    localparam int TableAddrBits = 10;
    localparam int SampleBits    = 16;
    localparam int StepBits      = 32;

    localparam int QtrBits  = TableAddrBits - 2;
    localparam int QtrLen   = 1 << QtrBits;
    localparam int MagBits  = SampleBits - 1;
    localparam int ProdBits = MagBits + SampleBits + 1;

    localparam longint unsigned HalfPiQ30 = 64'd1686629713;
    localparam longint unsigned Amp       = (64'd1 << (SampleBits - 1)) - 64'd1;

    // Taylor divisors (2n)(2n+1) for n = 1..8
    localparam longint unsigned TaylorDiv [1:8] = '{
        64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210, 64'd272
    };

    typedef enum logic [0:0] {
        CFG_CARRIER_STEP   = 1'b0,
        CFG_MODULATOR_STEP = 1'b1
    } t_cfg_index;

    typedef logic [MagBits-1:0] t_qrom [0:QtrLen-1];

    typedef struct packed {
        logic               neg;
        logic [MagBits-1:0] mag;
    } t_sine;

    // sin(x) for x in [0, pi/2], Q30, alternating series
    function automatic longint unsigned sine_q30(input longint unsigned x);
        longint unsigned term;
        longint unsigned plus;
        longint unsigned minus;
        term  = x;
        plus  = x;
        minus = 64'd0;
        for (int n = 1; n <= 8; n++) begin
            term = (term * x) >> 30;
            term = (term * x) >> 30;
            term = term / TaylorDiv[n];
            if ((n % 2) == 1) begin
                minus = minus + term;
            end else begin
                plus = plus + term;
            end
        end
        return (plus > minus) ? (plus - minus) : 64'd0;
    endfunction

    function automatic longint unsigned quarter_value(input longint unsigned r);
        longint unsigned x;
        longint unsigned s;
        x = (r * HalfPiQ30 + longint'(QtrLen / 2)) / QtrLen;
        s = sine_q30(x);
        return (s * Amp + (64'd1 << 29)) >> 30;
    endfunction

    function automatic t_qrom build_quarter();
        t_qrom rom;
        for (int k = 0; k < QtrLen; k++) begin
            rom[k] = MagBits'(quarter_value(longint'(k)));
        end
        return rom;
    endfunction

    localparam t_qrom QuarterRom = build_quarter();
    localparam logic [MagBits-1:0] QuarterPeak = MagBits'(quarter_value(longint'(QtrLen)));

    // Full-wave lookup from the quarter table: mirror odd quadrants, negate the lower half
    function automatic t_sine sine_lookup(input logic [TableAddrBits-1:0] addr);
        logic [1:0]         quad;
        logic [QtrBits-1:0] r;
        t_sine              res;
        quad    = addr[TableAddrBits-1 -: 2];
        r       = addr[QtrBits-1:0];
        res.neg = quad[1];
        if (quad[0] && (r == '0)) begin
            res.mag = QuarterPeak;
        end else if (quad[0]) begin
            res.mag = QuarterRom[QtrBits'(~r + 1'b1)];
        end else begin
            res.mag = QuarterRom[r];
        end
        return res;
    endfunction

endpackage

/* hdl/am_sine_oscillator.sv */
// Amplitude-modulated sine generator: two phase accumulators, sine lookup and AM product.
// A request is registered in the lookup stage, then in the output (multiply) stage.
// Throughput: one request per cycle while the output is not stalled.
// A stalled output holds both stages, and a new request is taken once a stage frees.
// Reset (synchronous, active low) clears both phases, both steps and all valid flags.
module am_sine_oscillator (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [0:0]                         i_cfg_index,
    input  logic [amso_pkg::StepBits-1:0]      i_cfg_data,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic                               i_end_of_buffer,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic signed [amso_pkg::SampleBits-1:0] o_audio_sample,
    output logic [amso_pkg::SampleBits-1:0]    o_modulator_level,
    output logic                               o_last_of_buffer
);
    import amso_pkg::*;

    localparam logic [SampleBits:0] LevelBias = (SampleBits + 1)'(1) << (SampleBits - 1);
    localparam logic [ProdBits-1:0] RoundBias = ProdBits'(1) << (SampleBits - 1);

    logic [StepBits-1:0]   r_car_step;
    logic [StepBits-1:0]   r_mod_step;
    logic [PhaseBits-1:0]  r_car_phase;
    logic [PhaseBits-1:0]  r_mod_phase;

    logic                  r_lk_valid;
    logic                  r_lk_neg;
    logic [MagBits-1:0]    r_lk_mag;
    logic [SampleBits-1:0] r_lk_level;
    logic                  r_lk_eob;

    logic                  r_out_valid;
    logic [SampleBits-1:0] r_out_sample;
    logic [SampleBits-1:0] r_out_level;
    logic                  r_out_eob;

    logic                  in_fire;
    logic                  lk_ready;
    logic                  out_ready;
    t_sine                 car_sine;
    t_sine                 mod_sine;
    logic [SampleBits:0]   level_sum;
    logic [ProdBits-1:0]   prod;
    logic [MagBits-1:0]    prod_mag;
    logic [SampleBits-1:0] n_sample;

    assign o_cfg_ready = 1'b1;

    assign out_ready  = !r_out_valid || i_out_ready;
    assign lk_ready   = !r_lk_valid || out_ready;
    assign o_in_ready = lk_ready;
    assign in_fire    = i_in_valid && lk_ready;

    always_comb begin
        car_sine  = sine_lookup(r_car_phase[PhaseBits-1 -: TableAddrBits]);
        mod_sine  = sine_lookup(r_mod_phase[PhaseBits-1 -: TableAddrBits]);
        // map -1..1 to 0..1 by adding half scale
        level_sum = mod_sine.neg ? (LevelBias - (SampleBits + 1)'(mod_sine.mag))
                                 : (LevelBias + (SampleBits + 1)'(mod_sine.mag));
        prod      = ProdBits'(r_lk_mag) * ProdBits'(r_lk_level) + RoundBias;
        prod_mag  = prod[SampleBits +: MagBits];
        n_sample  = r_lk_neg ? (SampleBits'(0) - SampleBits'(prod_mag))
                             : SampleBits'(prod_mag);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_car_step  <= '0;
            r_mod_step  <= '0;
            r_car_phase <= '0;
            r_mod_phase <= '0;
            r_lk_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                unique case (t_cfg_index'(i_cfg_index))
                    CFG_CARRIER_STEP:   r_car_step <= i_cfg_data;
                    CFG_MODULATOR_STEP: r_mod_step <= i_cfg_data;
                    default: ;
                endcase
            end
            // advance after the lookup so this request sees the old phases
            if (in_fire) begin
                r_car_phase <= r_car_phase + PhaseBits'(r_car_step);
                r_mod_phase <= r_mod_phase + PhaseBits'(r_mod_step);
            end
            if (lk_ready) begin
                r_lk_valid <= i_in_valid;
            end
            if (out_ready) begin
                r_out_valid <= r_lk_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_lk_neg   <= car_sine.neg;
            r_lk_mag   <= car_sine.mag;
            r_lk_level <= level_sum[SampleBits-1:0];
            r_lk_eob   <= i_end_of_buffer;
        end
        if (out_ready && r_lk_valid) begin
            r_out_sample <= n_sample;
            r_out_level  <= r_lk_level;
            r_out_eob    <= r_lk_eob;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_audio_sample    = signed'(r_out_sample);
    assign o_modulator_level = r_out_level;
    assign o_last_of_buffer  = r_out_eob;

    a_phase_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire && $past(i_rst_n) |=> r_car_phase == $past(r_car_phase + PhaseBits'(r_car_step)))
        else $error("carrier phase did not advance by its step");

    a_level_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_modulator_level != '0)
        else $error("modulator level left its range");

    a_sample_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> r_out_sample != (SampleBits'(1) << (SampleBits - 1)))
        else $error("audio sample reached the most negative code");

    a_stage_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_lk_valid && !out_ready |=> r_lk_valid && $stable(r_lk_mag))
        else $error("lookup stage lost a request under stall");

endmodule

/* tb/sv/tb_am_sine_oscillator.sv */
// Self-checking testbench for the amplitude-modulated sine oscillator.
`timescale 1ns / 1ps

module tb_am_sine_oscillator;

    import amso_pkg::*;

    localparam int PHASE_W  = amso_pkg::PhaseBits;
    localparam int ADDR_W   = amso_pkg::TableAddrBits;
    localparam int SAMPLE_W = amso_pkg::SampleBits;
    localparam int STEP_W   = amso_pkg::StepBits;

    localparam int WAVE_LEN = 1 << ADDR_W;
    localparam int QTR_LEN  = WAVE_LEN / 4;
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
    localparam longint unsigned PEAK        = (64'd1 << (SAMPLE_W - 1)) - 64'd1;

    localparam int SETTLE_CYCLES  = 4;
    localparam int TAIL_CYCLES    = 8;
    localparam int WATCHDOG_LIMIT = 2000;

    typedef enum logic [1:0] {
        REQ_TICK,
        REQ_CFG,
        REQ_DRAIN
    } req_kind_t;

    typedef struct {
        req_kind_t          kind;
        logic               eob;
        t_cfg_index         reg_sel;
        logic [STEP_W-1:0]  value;
        logic               may_idle;
    } plan_req_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] audio;
        logic [SAMPLE_W-1:0]        level;
        logic                       last;
    } am_sample_t;

    // DUT connections
    logic                       i_clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       cfg_valid = 1'b0;
    logic                       o_cfg_ready;
    t_cfg_index                 cfg_sel = CFG_CARRIER_STEP;
    logic [STEP_W-1:0]          cfg_data = '0;
    logic                       tick_valid = 1'b0;
    logic                       o_in_ready;
    logic                       tick_eob = 1'b0;
    logic                       o_out_valid;
    logic                       out_ready = 1'b0;
    logic signed [SAMPLE_W-1:0] o_audio_sample;
    logic [SAMPLE_W-1:0]        o_modulator_level;
    logic                       o_last_of_buffer;

    // Oscillator copy
    int                         sine_wave [0:WAVE_LEN-1];
    logic [PHASE_W-1:0]         carrier_acc = '0;
    logic [PHASE_W-1:0]         modulator_acc = '0;
    logic [STEP_W-1:0]          carrier_inc = '0;
    logic [STEP_W-1:0]          modulator_inc = '0;

    plan_req_t                  request_plan [$];
    am_sample_t                 due_samples [$];

    int  gap_left = 0;
    bit  gap_taken = 1'b0;
    int  quiet_cycles = 0;
    int  stall_left = 0;
    logic idling_on = 1'b0;
    int  idle_cycles = 0;

    int  mismatches = 0;
    int  ticks_accepted = 0;
    int  writes_accepted = 0;
    int  samples_checked = 0;
    int  buffer_ends = 0;
    int  level_min = 65535;
    int  level_max = 0;

    am_sine_oscillator uut (
        .i_clk             (i_clk),
        .i_rst_n           (rst_n),
        .i_cfg_valid       (cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (cfg_sel),
        .i_cfg_data        (cfg_data),
        .i_in_valid        (tick_valid),
        .o_in_ready        (o_in_ready),
        .i_end_of_buffer   (tick_eob),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (out_ready),
        .o_audio_sample    (o_audio_sample),
        .o_modulator_level (o_modulator_level),
        .o_last_of_buffer  (o_last_of_buffer)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Quarter-wave magnitude from an integer Taylor series in Q30
    function automatic longint unsigned quarter_wave_mag(input longint unsigned r);
        longint unsigned x;
        longint unsigned term;
        longint unsigned pos_sum;
        longint unsigned neg_sum;
        longint unsigned den;
        x       = (r * HALF_PI_Q30 + QTR_LEN / 2) / QTR_LEN;
        term    = x;
        pos_sum = x;
        neg_sum = 64'd0;
        for (int n = 1; n <= 8; n++) begin
            term = (term * x) >> 30;
            term = (term * x) >> 30;
            den  = longint'(2 * n) * longint'(2 * n + 1);
            term = term / den;
            if ((n % 2) == 1) begin
                neg_sum += term;
            end else begin
                pos_sum += term;
            end
        end
        x = (pos_sum > neg_sum) ? (pos_sum - neg_sum) : 64'd0;
        return (x * PEAK + (64'd1 << 29)) >> 30;
    endfunction

    initial begin : wave_build
        int quad;
        int r;
        int m;
        for (int k = 0; k < WAVE_LEN; k++) begin
            quad = k / QTR_LEN;
            r    = k % QTR_LEN;
            m    = int'(quarter_wave_mag(longint'((quad % 2) ? (QTR_LEN - r) : r)));
            sine_wave[k] = (quad >= 2) ? -m : m;
        end
    end

    // Work out the sample for one tick, then advance both phases
    task automatic predict_am_sample(input logic eob);
        int         carrier_val;
        int         level;
        longint     mag;
        am_sample_t s;
        carrier_val = sine_wave[carrier_acc[PHASE_W-1 -: ADDR_W]];
        level       = sine_wave[modulator_acc[PHASE_W-1 -: ADDR_W]] + (1 << (SAMPLE_W - 1));
        mag         = (carrier_val < 0) ? -carrier_val : carrier_val;
        mag         = (mag * level + (1 << (SAMPLE_W - 1))) >>> SAMPLE_W;
        s.audio     = SAMPLE_W'((carrier_val < 0) ? -mag : mag);
        s.level     = SAMPLE_W'(level);
        s.last      = eob;
        due_samples.push_back(s);
        carrier_acc   = carrier_acc + PHASE_W'(carrier_inc);
        modulator_acc = modulator_acc + PHASE_W'(modulator_inc);
    endtask

    task automatic flag_mismatch(input string what, input longint got, input longint want);
        mismatches++;
        $display("MISMATCH sample %0d: %s got %0d expected %0d",
                 samples_checked, what, got, want);
    endtask

    task automatic plan_tick(input logic eob, input logic may_idle);
        plan_req_t req;
        req = '{kind: REQ_TICK, eob: eob, reg_sel: CFG_CARRIER_STEP, value: '0,
                may_idle: may_idle};
        request_plan.push_back(req);
    endtask

    task automatic plan_write(input t_cfg_index sel, input logic [STEP_W-1:0] value);
        plan_req_t req;
        req = '{kind: REQ_CFG, eob: 1'b0, reg_sel: sel, value: value, may_idle: 1'b0};
        request_plan.push_back(req);
    endtask

    function automatic logic [STEP_W-1:0] random_step();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            2:       return STEP_W'($urandom_range(1, (1 << (PHASE_W - ADDR_W)) - 1));
            3:       return STEP_W'($urandom_range(0, WAVE_LEN - 1)) << (PHASE_W - ADDR_W);
            default: return STEP_W'($urandom());
        endcase
    endfunction

    // Request driver: presents ticks and register writes from the plan
    always @(posedge i_clk) begin : request_driver
        logic      next_tick_valid;
        logic      next_cfg_valid;
        plan_req_t head;
        if (!rst_n) begin
            tick_valid   <= 1'b0;
            cfg_valid    <= 1'b0;
            gap_left     = 0;
            gap_taken    = 1'b0;
            quiet_cycles = 0;
        end else begin
            next_tick_valid = tick_valid;
            next_cfg_valid  = cfg_valid;
            if (tick_valid && o_in_ready) begin
                predict_am_sample(tick_eob);
                ticks_accepted++;
                next_tick_valid = 1'b0;
            end
            if (cfg_valid && o_cfg_ready) begin
                case (cfg_sel)
                    CFG_CARRIER_STEP:   carrier_inc = cfg_data;
                    CFG_MODULATOR_STEP: modulator_inc = cfg_data;
                    default: ;
                endcase
                writes_accepted++;
                next_cfg_valid = 1'b0;
            end
            if (due_samples.size() == 0 && !next_tick_valid && !next_cfg_valid) begin
                quiet_cycles++;
            end else begin
                quiet_cycles = 0;
            end
            if (gap_left > 0) begin
                gap_left--;
            end else if (!next_tick_valid && !next_cfg_valid && request_plan.size() != 0) begin
                head = request_plan[0];
                case (head.kind)
                    REQ_TICK: begin
                        if (head.may_idle && !gap_taken && $urandom_range(0, 3) == 0) begin
                            gap_left  = $urandom_range(0, 10);
                            gap_taken = 1'b1;
                        end else begin
                            void'(request_plan.pop_front());
                            next_tick_valid = 1'b1;
                            tick_eob  <= head.eob;
                            idling_on <= head.may_idle;
                            gap_taken = 1'b0;
                        end
                    end
                    REQ_CFG: begin
                        // write registers only once the pipeline has emptied and settled
                        if (quiet_cycles >= SETTLE_CYCLES) begin
                            void'(request_plan.pop_front());
                            next_cfg_valid = 1'b1;
                            cfg_sel  <= head.reg_sel;
                            cfg_data <= head.value;
                        end
                    end
                    REQ_DRAIN: begin
                        if (quiet_cycles >= 1) begin
                            void'(request_plan.pop_front());
                        end
                    end
                    default: void'(request_plan.pop_front());
                endcase
            end
            tick_valid <= next_tick_valid;
            cfg_valid  <= next_cfg_valid;
        end
    end

    // Sample monitor: checks each accepted sample and throttles the output side
    always @(posedge i_clk) begin : sample_monitor
        am_sample_t want;
        if (!rst_n) begin
            out_ready  <= 1'b0;
            stall_left = 0;
        end else begin
            if (o_out_valid && out_ready) begin
                if (o_last_of_buffer) begin
                    buffer_ends++;
                end
                if (int'(o_modulator_level) < level_min) level_min = int'(o_modulator_level);
                if (int'(o_modulator_level) > level_max) level_max = int'(o_modulator_level);
                if (due_samples.size() == 0) begin
                    flag_mismatch("sample with none outstanding", o_audio_sample, 0);
                end else begin
                    want = due_samples.pop_front();
                    if (o_audio_sample !== want.audio) begin
                        flag_mismatch("audio_sample", o_audio_sample, want.audio);
                    end
                    if (o_modulator_level !== want.level) begin
                        flag_mismatch("modulator_level", o_modulator_level, want.level);
                    end
                    if (o_last_of_buffer !== want.last) begin
                        flag_mismatch("last_of_buffer", o_last_of_buffer, want.last);
                    end
                end
                samples_checked++;
            end
            if (stall_left > 0) begin
                stall_left--;
                out_ready <= 1'b0;
            end else if (idling_on && $urandom_range(0, 4) == 0) begin
                stall_left = $urandom_range(0, 10);
                out_ready  <= 1'b0;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin : watchdog
        if (!rst_n || (tick_valid && o_in_ready) || (cfg_valid && o_cfg_ready)
                || (o_out_valid && out_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Timeout: no handshake for %0d cycles", idle_cycles);
            $display("*** FAILED ***");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : stimulus
        int   count;
        int   buf_left;
        logic eob;
        logic idle_ok;

        // Steps at reset are zero: first samples sit at phase zero
        plan_tick(1'b0, 1'b1);
        plan_tick(1'b1, 1'b1);

        // Quarter-turn steps hit zero crossings, both peaks and the level extremes
        plan_write(CFG_CARRIER_STEP, 32'h4000_0000);
        plan_write(CFG_MODULATOR_STEP, 32'hC000_0000);
        for (int i = 0; i < 8; i++) begin
            plan_tick(logic'(i == 7), 1'b1);
        end

        // Largest steps: both phases step back by one LSB each tick and wrap below zero
        plan_write(CFG_CARRIER_STEP, 32'hFFFF_FFFF);
        plan_write(CFG_MODULATOR_STEP, 32'hFFFF_FFFF);
        for (int i = 0; i < 4; i++) begin
            plan_tick(logic'(i % 2), 1'b1);
        end

        // One table entry per tick on the carrier, slow modulator
        plan_write(CFG_CARRIER_STEP, 32'h0040_0000);
        plan_write(CFG_MODULATOR_STEP, 32'h0000_0001);
        for (int i = 0; i < 5; i++) begin
            plan_tick(logic'(i == 4), 1'b1);
        end

        for (int p = 0; p < 8; p++) begin
            idle_ok = (p != 2) && (p < 6);
            case ($urandom_range(0, 3))
                0: begin
                    plan_write(CFG_CARRIER_STEP, random_step());
                    plan_write(CFG_MODULATOR_STEP, random_step());
                end
                1: begin
                    plan_write(CFG_MODULATOR_STEP, random_step());
                    plan_write(CFG_CARRIER_STEP, random_step());
                end
                2: plan_write(CFG_CARRIER_STEP, random_step());
                default: plan_write(CFG_MODULATOR_STEP, random_step());
            endcase
            count    = $urandom_range(70, 100);
            buf_left = $urandom_range(1, 48);
            for (int i = 0; i < count; i++) begin
                buf_left--;
                eob = (buf_left == 0);
                if (eob) begin
                    buf_left = $urandom_range(1, 48);
                end
                // occasional stray or missing buffer mark
                if ($urandom_range(0, 15) == 0) begin
                    eob = ~eob;
                end
                plan_tick(eob, idle_ok);
                if (p == 3 && i == count / 2) begin
                    request_plan.push_back('{kind: REQ_DRAIN, eob: 1'b0,
                                             reg_sel: CFG_CARRIER_STEP, value: '0,
                                             may_idle: 1'b0});
                end
            end
        end

        repeat (8) @(posedge i_clk);
        rst_n <= 1'b1;

        while (request_plan.size() != 0 || tick_valid || cfg_valid || due_samples.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (due_samples.size() != 0) begin
            flag_mismatch("samples still outstanding", due_samples.size(), 0);
        end
        $display("Covered %0d ticks, %0d step writes, %0d samples checked, %0d buffer ends",
                 ticks_accepted, writes_accepted, samples_checked, buffer_ends);
        $display("Modulator level seen from %0d to %0d, %0d mismatches",
                 level_min, level_max, mismatches);
        if (mismatches == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
